// File: rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
package u8dec_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int PENDING_W = 3;
    localparam int TDATA_OUT_W = 16;

    localparam logic [UNIT_W-1:0]    SPACE_UNIT  = 16'h0020;
    localparam logic [PENDING_W-1:0] SKIP_FOUR   = 3'd3;
    localparam logic [PENDING_W-1:0] SKIP_FIVE   = 3'd4;
    localparam logic [PENDING_W-1:0] SKIP_OTHER  = 3'd5;
    localparam logic [PENDING_W-1:0] PEND_TWO    = 3'd1;
    localparam logic [PENDING_W-1:0] PEND_THREE  = 3'd2;

    localparam logic [2:0] LEAD_TWO   = 3'b110;
    localparam logic [3:0] LEAD_THREE = 4'b1110;
    localparam logic [4:0] LEAD_FOUR  = 5'b11110;
    localparam logic [5:0] LEAD_FIVE  = 6'b111110;

    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] code_unit;
        logic              substituted;
    } t_result;

endpackage

// File: rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to 16-bit code unit decoder with its stream ports.
//
// Bytes of a UTF-8 string enter on the slave channel, one request per byte,
// with tlast marking the final byte of the string. Code units leave on the
// master channel, one request per decoded character or substituted space;
// tuser is high when a space replaced an unsupported or truncated sequence.
// Bytes that complete nothing, such as two- or three-byte leads before the
// final byte or skipped bytes, give no request on the master channel.
// An accepted byte is held in an input register, decoded in one pass of
// logic and its result is stored in the output register, from which the
// code unit is offered. One byte is taken every cycle while the receiver
// keeps up; a waiting result does not stop the input register from
// filling.
// Reset clears the valid flags of both registers and the sequence state. When the receiver
// stalls, the output request is held unchanged and the input stops once the
// input register is occupied behind it.
module utf8_to_ucs2_decoder
    import u8dec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] in_byte
    input  logic                   i_s_axis_tlast,   // string_last
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic                   o_m_axis_tuser    // [0] substituted
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic [UNIT_W-1:0] r_out_unit;
    logic              r_out_sub;
    logic              out_free;
    logic              fire;
    logic              accept;
    t_result           result;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    u8dec_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_in_byte     (r_in_byte),
        .i_string_last (r_in_last),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= result.emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.emit) begin
            r_out_unit <= result.code_unit;
            r_out_sub  <= result.substituted;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_unit;
    assign o_m_axis_tuser  = r_out_sub;

endmodule

// File: rtl/u8dec_decode.sv
// Sequence state and single-pass decode logic for one registered input byte.
module u8dec_decode
    import u8dec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_string_last,
    output t_result           o_result
);

    logic [PENDING_W-1:0] r_pending;
    logic                 r_skipping;
    logic [UNIT_W-1:0]    r_partial;
    logic [PENDING_W-1:0] n_pending;
    logic                 n_skipping;
    logic [UNIT_W-1:0]    n_partial;
    logic [PENDING_W-1:0] pending_dec;
    logic [UNIT_W-1:0]    cont_bits;

    assign pending_dec = r_pending - PENDING_W'(1);
    assign cont_bits   = {10'b0, i_in_byte[5:0]};

    always_comb begin
        n_pending  = r_pending;
        n_skipping = r_skipping;
        n_partial  = r_partial;
        o_result   = '0;
        if (r_skipping) begin
            if (r_pending != '0) begin
                n_pending = pending_dec;
            end
            if (r_pending <= PENDING_W'(1)) begin
                n_skipping = 1'b0;
            end
        end else if (r_pending >= PEND_THREE) begin
            if (i_string_last) begin
                o_result = '{emit: 1'b1, code_unit: SPACE_UNIT, substituted: 1'b1};
            end else begin
                n_partial = r_partial | (cont_bits << 6);
                n_pending = pending_dec;
            end
        end else if (r_pending == PEND_TWO) begin
            o_result  = '{emit: 1'b1, code_unit: r_partial | cont_bits, substituted: 1'b0};
            n_pending = '0;
            n_partial = '0;
        end else if (!i_in_byte[7]) begin
            o_result = '{emit: 1'b1, code_unit: {8'b0, i_in_byte}, substituted: 1'b0};
        end else if (i_in_byte[7:5] == LEAD_TWO) begin
            if (i_string_last) begin
                o_result = '{emit: 1'b1, code_unit: SPACE_UNIT, substituted: 1'b1};
            end else begin
                n_partial = cont_bits << 6;
                n_pending = PEND_TWO;
            end
        end else if (i_in_byte[7:4] == LEAD_THREE) begin
            if (i_string_last) begin
                o_result = '{emit: 1'b1, code_unit: SPACE_UNIT, substituted: 1'b1};
            end else begin
                n_partial = {i_in_byte[3:0], 12'b0};
                n_pending = PEND_THREE;
            end
        end else begin
            o_result   = '{emit: 1'b1, code_unit: SPACE_UNIT, substituted: 1'b1};
            n_skipping = 1'b1;
            n_partial  = '0;
            if (i_in_byte[7:3] == LEAD_FOUR) begin
                n_pending = SKIP_FOUR;
            end else if (i_in_byte[7:2] == LEAD_FIVE) begin
                n_pending = SKIP_FIVE;
            end else begin
                n_pending = SKIP_OTHER;
            end
        end
        if (i_string_last) begin
            n_pending  = '0;
            n_skipping = 1'b0;
            n_partial  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_skipping <= 1'b0;
            r_partial  <= '0;
        end else if (i_fire) begin
            r_pending  <= n_pending;
            r_skipping <= n_skipping;
            r_partial  <= n_partial;
        end
    end

endmodule
